// ===== src/i2cwf_pkg.sv =====
// Shared types and constants of the I2C write-frame master.
package i2cwf_pkg;

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 24;

   localparam logic [1:0] KIND_COMMAND = 2'd0;
   localparam logic [1:0] KIND_DATA    = 2'd1;
   localparam logic [1:0] KIND_PROBE   = 2'd2;
   // undefined kind, runs as a command frame
   localparam logic [1:0] KIND_SPARE   = 2'd3;

   localparam logic [7:0]  CTRL_COMMAND = 8'h00;
   localparam logic [7:0]  CTRL_DATA    = 8'h40;
   localparam logic [6:0]  ADDR_RESET   = 7'h3C;
   localparam logic [15:0] ERR_MAX      = 16'hFFFF;
   localparam logic [2:0]  LAST_BIT     = 3'd7;

   typedef enum logic [11:0] {
      PH_IDLE    = 12'h001,
      PH_SDA_LOW = 12'h002,
      PH_SCL_LOW = 12'h004,
      PH_BIT_HI  = 12'h008,
      PH_BIT_LO  = 12'h010,
      PH_ACK_REL = 12'h020,
      PH_ACK_HI  = 12'h040,
      PH_ACK_LO  = 12'h080,
      PH_WAIT    = 12'h100,
      PH_STOP_A  = 12'h200,
      PH_STOP_B  = 12'h400,
      PH_STOP_C  = 12'h800
   } phase_type;

   typedef enum logic [1:0] {
      ROLE_ADDRESS = 2'd0,
      ROLE_CONTROL = 2'd1,
      ROLE_DATA    = 2'd2,
      ROLE_LAST    = 2'd3
   } role_type;

   // one classified item as it travels from the front to the engine
   typedef struct packed {
      logic       is_push;
      logic       sda;
      logic [7:0] data_byte;
      logic       first;
      logic       last;
      logic [1:0] kind;
   } item_type;

endpackage

// ===== src/i2c_write_frame_master_unit.sv =====
// Write-only I2C master: a request item is either one bus delay tick or one pushed
// byte, and every accepted item yields exactly one response item carrying the SCL
// and SDA drive, the holding-register state, STOP and NACK pulses and the saturating
// error count. Items are taken at one per clock while the queue has room: a two-entry
// queue parts the input from the bus sequencer, which steps once per item, and a
// response register parts the sequencer from the output. A response is registered when
// its item leaves the queue while the response register is free or being taken; either
// side may stall without stopping the other. The slave address register may be written
// only while no item is in flight.
module i2c_write_frame_master_unit
   import i2cwf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [6:0]            csr_write_data,   // slave_address
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sda_in, data_byte[7:0], zero fill
   input  logic [REQ_USER_W-1:0] req_tuser,   // action, frame_first, frame_kind[1:0]
   input  logic                  req_tlast,   // frame_last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // scl_out, sda_out, byte_ready, probe_ack, nack_seen, error_total[15:0], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast    // frame_done
);

   logic     q_valid;
   logic     q_ready;
   item_type q_item;

   i2cwf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item)
   );

   i2cwf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_item           (q_item),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast)
   );

endmodule

// ===== src/i2cwf_front.sv =====
// Input side: accept stream items, classify them and queue them for the engine.
module i2cwf_front
   import i2cwf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // sda_in, data_byte, zero fill
   input  logic [REQ_USER_W-1:0] req_tuser,  // action, frame_first, frame_kind
   input  logic                  req_tlast,
   output logic                  q_valid,
   input  logic                  q_ready,
   output item_type              q_item
);

   item_type   slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   item_type   new_item;
   logic       push, pop;

   always_comb begin
      new_item.is_push   = req_tuser[0];
      new_item.sda       = req_tdata[0];
      new_item.data_byte = req_tdata[8:1];
      new_item.first     = req_tuser[1];
      new_item.last      = req_tlast;
      new_item.kind      = req_tuser[3:2];
   end

   assign req_tready = (count_ff != 2'd2);
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |=> (count_ff == 2'd0 || count_ff == 2'd1))
      else $error("queue grew by more than one item");

endmodule

// ===== src/i2cwf_back.sv =====
// Bus engine: step the SCL/SDA sequencer one item at a time and register each result.
module i2cwf_back
   import i2cwf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [6:0]            csr_write_data,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  item_type              q_item,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   phase_type  phase_ff, phase_in;
   role_type   role_ff, role_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] held_byte_ff;
   logic       held_valid_ff, held_valid_in;
   logic       held_first_ff, held_last_ff;
   logic [1:0] held_kind_ff;
   logic       load_held;
   logic       disc_ff, disc_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic [15:0] err_ff, err_in;
   logic [6:0] addr_ff;
   logic       rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff;
   logic       done, probe, nack, do_next, pop;

   assign q_ready    = !rsp_valid_ff || rsp_tready;
   assign pop        = q_valid && q_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      phase_in      = phase_ff;
      role_in       = role_ff;
      bit_in        = bit_ff;
      shift_in      = shift_ff;
      kind_in       = kind_ff;
      held_valid_in = held_valid_ff;
      load_held     = 1'b0;
      disc_in       = disc_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      err_in        = err_ff;
      done          = 1'b0;
      probe         = 1'b0;
      nack          = 1'b0;
      do_next       = 1'b0;

      if (q_item.is_push) begin
         // a push into a full holding register is dropped
         if (!held_valid_ff) begin
            load_held     = 1'b1;
            held_valid_in = 1'b1;
         end
      end else begin
         unique case (phase_ff)
            PH_SDA_LOW: begin
               scl_in   = 1'b1;
               sda_in   = 1'b0;
               phase_in = PH_SCL_LOW;
            end
            PH_SCL_LOW: begin
               scl_in = 1'b0;
               sda_in = 1'b0;
               if (kind_ff != KIND_PROBE) begin
                  shift_in = {addr_ff, 1'b0};
               end
               role_in  = ROLE_ADDRESS;
               bit_in   = 3'd0;
               phase_in = PH_BIT_HI;
            end
            PH_BIT_HI: begin
               scl_in   = 1'b1;
               sda_in   = shift_ff[7];
               phase_in = PH_BIT_LO;
            end
            PH_BIT_LO: begin
               scl_in   = 1'b0;
               sda_in   = shift_ff[7];
               shift_in = {shift_ff[6:0], 1'b0};
               if (bit_ff == LAST_BIT) begin
                  bit_in   = 3'd0;
                  phase_in = PH_ACK_REL;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  phase_in = PH_BIT_HI;
               end
            end
            PH_ACK_REL: begin
               scl_in   = 1'b0;
               sda_in   = 1'b1;
               phase_in = PH_ACK_HI;
            end
            PH_ACK_HI: begin
               scl_in   = 1'b1;
               sda_in   = 1'b1;
               nack     = q_item.sda;
               // keep the ACK result in the shifter's low bit
               shift_in = {7'd0, ~q_item.sda};
               if (q_item.sda && kind_ff != KIND_PROBE && err_ff != ERR_MAX) begin
                  err_in = err_ff + 16'd1;
               end
               phase_in = PH_ACK_LO;
            end
            PH_ACK_LO: begin
               scl_in = 1'b0;
               sda_in = 1'b1;
               priority if (kind_ff == KIND_PROBE) begin
                  phase_in = PH_STOP_A;
               end else if (!shift_ff[0]) begin
                  if (role_ff == ROLE_ADDRESS || role_ff == ROLE_CONTROL) begin
                     disc_in       = held_valid_ff && !held_last_ff;
                     held_valid_in = 1'b0;
                  end else begin
                     disc_in = (role_ff == ROLE_DATA);
                  end
                  phase_in = PH_STOP_A;
               end else if (role_ff == ROLE_ADDRESS) begin
                  shift_in = (kind_ff == KIND_DATA) ? CTRL_DATA : CTRL_COMMAND;
                  role_in  = ROLE_CONTROL;
                  bit_in   = 3'd0;
                  phase_in = PH_BIT_HI;
               end else if (role_ff == ROLE_CONTROL || role_ff == ROLE_DATA) begin
                  do_next = 1'b1;
               end else begin
                  phase_in = PH_STOP_A;
               end
            end
            PH_WAIT: begin
               scl_in  = 1'b0;
               sda_in  = 1'b1;
               do_next = 1'b1;
            end
            PH_STOP_A: begin
               scl_in   = 1'b0;
               sda_in   = 1'b0;
               phase_in = PH_STOP_B;
            end
            PH_STOP_B: begin
               scl_in   = 1'b1;
               sda_in   = 1'b0;
               phase_in = PH_STOP_C;
            end
            PH_STOP_C: begin
               scl_in   = 1'b1;
               sda_in   = 1'b1;
               done     = 1'b1;
               probe    = (kind_ff == KIND_PROBE) && shift_ff[0];
               phase_in = PH_IDLE;
            end
            default: begin
               scl_in   = 1'b1;
               sda_in   = 1'b1;
               phase_in = PH_IDLE;
               if (held_valid_ff) begin
                  if (disc_ff && !held_first_ff) begin
                     // drop the rest of a frame that saw a NACK
                     if (held_last_ff) begin
                        disc_in = 1'b0;
                     end
                     held_valid_in = 1'b0;
                  end else begin
                     disc_in = 1'b0;
                     kind_in = (held_kind_ff == KIND_SPARE) ? KIND_COMMAND : held_kind_ff;
                     if (kind_in == KIND_PROBE) begin
                        shift_in      = {held_byte_ff[6:0], 1'b0};
                        held_valid_in = 1'b0;
                     end
                     phase_in = PH_SDA_LOW;
                  end
               end
            end
         endcase

         // fetch the next data byte, or hold with SCL low, or close on a new frame
         if (do_next) begin
            if (held_valid_ff) begin
               if (role_ff != ROLE_CONTROL && held_first_ff) begin
                  phase_in = PH_STOP_A;
               end else begin
                  shift_in      = held_byte_ff;
                  role_in       = held_last_ff ? ROLE_LAST : ROLE_DATA;
                  held_valid_in = 1'b0;
                  bit_in        = 3'd0;
                  phase_in      = PH_BIT_HI;
               end
            end else begin
               phase_in = PH_WAIT;
            end
         end
      end

      rsp_data_in = {3'd0, err_in, nack, probe, ~held_valid_in, sda_in, scl_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         role_ff       <= ROLE_ADDRESS;
         bit_ff        <= 3'd0;
         shift_ff      <= 8'd0;
         kind_ff       <= KIND_COMMAND;
         held_valid_ff <= 1'b0;
         disc_ff       <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         err_ff        <= 16'd0;
         addr_ff       <= ADDR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            addr_ff <= csr_write_data;
         end
         if (pop) begin
            phase_ff      <= phase_in;
            role_ff       <= role_in;
            bit_ff        <= bit_in;
            shift_ff      <= shift_in;
            kind_ff       <= kind_in;
            held_valid_ff <= held_valid_in;
            disc_ff       <= disc_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in;
            err_ff        <= err_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && load_held) begin
         held_byte_ff  <= q_item.data_byte;
         held_first_ff <= q_item.first;
         held_last_ff  <= q_item.last;
         held_kind_ff  <= q_item.kind;
      end
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= done;
      end
   end

   a_err_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (err_ff >= $past(err_ff)))
      else $error("error counter went down");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (phase_ff == PH_IDLE))
      else $error("frame done shown while bus not idle");

   a_bit_phase: assert property (@(posedge clock) disable iff (reset)
      (bit_ff != 3'd0) |-> (phase_ff == PH_BIT_HI || phase_ff == PH_BIT_LO))
      else $error("bit index live outside a data bit");

   a_stop_lines: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_STOP_C) |-> (scl_ff && !sda_ff))
      else $error("STOP setup lines wrong");

endmodule
